### sv/i2cmb_pkg.sv
// Shared types and codes for the I2C master register burst core.
// No dependencies; the FIFO, engine and top-level files import this package.
package i2cmb_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_PUSH  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_PRE_REL = 5'd1,
    PH_ST_SDA  = 5'd2,
    PH_ST_SCL  = 5'd3,
    PH_WB_SDA  = 5'd4,
    PH_WB_REL  = 5'd5,
    PH_WB_LOW  = 5'd6,
    PH_WA_SDA  = 5'd7,
    PH_WA_REL  = 5'd8,
    PH_WA_LOW  = 5'd9,
    PH_RS_REL  = 5'd10,
    PH_LOAD    = 5'd11,
    PH_RB_REL  = 5'd12,
    PH_RB_LOW  = 5'd13,
    PH_RK_SDA  = 5'd14,
    PH_RK_REL  = 5'd15,
    PH_RK_LOW  = 5'd16,
    PH_RK_FREE = 5'd17,
    PH_SP_SDA  = 5'd18,
    PH_SP_REL  = 5'd19,
    PH_SP_FREE = 5'd20
  } phase_e;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_ADDR_R = 2'd2,
    STG_DATA   = 2'd3
  } stage_e;

  localparam logic [2:0] BitLast = 3'd7;

  typedef struct packed {
    func_e       func;
    logic [6:0]  device_address;
    logic [7:0]  register_command;
    logic [7:0]  byte_count;
    logic [7:0]  tx_byte;
    logic        first_segment;
    logic        end_with_stop;
    logic        sda_sampled;
    logic        scl_stretched;
  } in_item_t;

  typedef struct packed {
    logic        scl_drive;
    logic        sda_drive;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic        done_res;
    logic        success;
    logic        engine_busy;
  } result_t;

  // FIFO status seen by the engine
  typedef struct packed {
    logic        nonempty;
    logic [7:0]  head_data;
  } fifo_stat_t;

endpackage

### sv/i2cmb_if.sv
// Valid/ready channel interfaces for the input and result beats.
// No dependencies.
interface i2cmb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [6:0]  device_address;
  logic [7:0]  register_command;
  logic [7:0]  byte_count;
  logic [7:0]  tx_byte;
  logic        first_segment;
  logic        end_with_stop;
  logic        sda_sampled;
  logic        scl_stretched;

  modport source (
    output valid, func, device_address, register_command, byte_count, tx_byte,
           first_segment, end_with_stop, sda_sampled, scl_stretched,
    input  ready
  );
  modport sink (
    input  valid, func, device_address, register_command, byte_count, tx_byte,
           first_segment, end_with_stop, sda_sampled, scl_stretched,
    output ready
  );
endinterface

interface i2cmb_out_if;
  logic        valid;
  logic        ready;
  logic        scl_drive;
  logic        sda_drive;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic        done_res;
  logic        success;
  logic        engine_busy;

  modport source (
    output valid, scl_drive, sda_drive, rx_byte, rx_valid, done_res, success,
           engine_busy,
    input  ready
  );
  modport sink (
    input  valid, scl_drive, sda_drive, rx_byte, rx_valid, done_res, success,
           engine_busy,
    output ready
  );
endinterface

### sv/i2cmb_fifo.sv
// Transmit data FIFO with a registered head read.
// Depends on i2cmb_pkg.
module i2cmb_fifo #(
  parameter int TxFifoDepth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [7:0]             push_data_i,
  input  logic                   pop_i,
  output i2cmb_pkg::fifo_stat_t  stat_o
);
  import i2cmb_pkg::*;

  localparam int AW = (TxFifoDepth > 1) ? $clog2(TxFifoDepth) : 1;
  localparam int CW = $clog2(TxFifoDepth + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DepthS = SW'(TxFifoDepth);
  localparam logic [CW-1:0] DepthC = CW'(TxFifoDepth);
  localparam logic [AW-1:0] HeadLast = AW'(TxFifoDepth - 1);

  logic [7:0]    mem_q [TxFifoDepth];
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rd_q;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          we, re;

  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign we       = push_i && (count_q != DepthC);
  assign re       = pop_i && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (re) begin
      head_d  = (head_q == HeadLast) ? '0 : head_q + AW'(1);
      count_d = count_q - CW'(1);
    end else if (we) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[tail] <= push_data_i;
    end
  end

  // Head data is prefetched; a write into the empty head slot bypasses.
  always_ff @(posedge clk_i) begin
    if (we && (tail == head_d)) begin
      rd_q <= push_data_i;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign stat_o.nonempty  = (count_q != '0);
  assign stat_o.head_data = rd_q;

endmodule

### sv/i2cmb_engine.sv
// Bus phase sequencer: at most one phase step per tick beat, plus begin handling.
// Depends on i2cmb_pkg.
module i2cmb_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   begin_i,
  input  i2cmb_pkg::in_item_t    item_i,
  input  i2cmb_pkg::fifo_stat_t  fifo_i,
  output logic                   pop_o,
  output i2cmb_pkg::result_t     res_o
);
  import i2cmb_pkg::*;

  phase_e     phase_q, phase_d;
  stage_e     stage_q, stage_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] bytes_q, bytes_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] reg_q, reg_d;
  logic       f_read_q, f_read_d;
  logic       f_end_q, f_end_d;
  logic       f_ok_q, f_ok_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  logic [7:0] bytes_dec;
  logic       bytes_dec_zero;
  logic       bit_last;
  logic       start_ok;
  logic [7:0] rd_shift;

  assign bytes_dec      = (bytes_q == '0) ? '0 : bytes_q - 8'd1;
  assign bytes_dec_zero = (bytes_dec == '0);
  assign bit_last       = (bit_q == BitLast);
  assign start_ok       = (phase_q == PH_IDLE) && (item_i.byte_count != '0);
  assign rd_shift       = {shift_q[6:0], item_i.sda_sampled};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (begin_i) begin
      if (start_ok) begin
        if (item_i.func == FUNC_READ && !item_i.first_segment) begin
          phase_d = PH_PRE_REL;
        end else begin
          phase_d = PH_ST_SDA;
        end
      end
    end else if (tick_i) begin
      unique case (phase_q)
        PH_PRE_REL: if (!item_i.scl_stretched) phase_d = PH_ST_SDA;
        PH_ST_SDA:  phase_d = PH_ST_SCL;
        PH_ST_SCL:  phase_d = PH_WB_SDA;
        PH_WB_SDA:  phase_d = PH_WB_REL;
        PH_WB_REL:  if (!item_i.scl_stretched) phase_d = PH_WB_LOW;
        PH_WB_LOW:  phase_d = bit_last ? PH_WA_SDA : PH_WB_SDA;
        PH_WA_SDA:  phase_d = PH_WA_REL;
        PH_WA_REL:  if (!item_i.scl_stretched) phase_d = PH_WA_LOW;
        PH_WA_LOW: begin
          if (item_i.sda_sampled) begin
            phase_d = PH_SP_SDA;
          end else begin
            unique case (stage_q)
              STG_ADDR_W: phase_d = PH_WB_SDA;
              STG_REG:    phase_d = f_read_q ? PH_RS_REL : PH_LOAD;
              STG_ADDR_R: phase_d = PH_RB_REL;
              default:    phase_d = bytes_dec_zero ? PH_SP_SDA : PH_LOAD;
            endcase
          end
        end
        PH_RS_REL:  if (!item_i.scl_stretched) phase_d = PH_ST_SDA;
        PH_LOAD:    if (fifo_i.nonempty) phase_d = PH_WB_SDA;
        PH_RB_REL:  if (!item_i.scl_stretched) phase_d = PH_RB_LOW;
        PH_RB_LOW:  phase_d = bit_last ? PH_RK_SDA : PH_RB_REL;
        PH_RK_SDA:  phase_d = PH_RK_REL;
        PH_RK_REL:  if (!item_i.scl_stretched) phase_d = PH_RK_LOW;
        PH_RK_LOW:  phase_d = PH_RK_FREE;
        PH_RK_FREE: begin
          if (!bytes_dec_zero) begin
            phase_d = PH_RB_REL;
          end else begin
            phase_d = f_end_q ? PH_SP_SDA : PH_IDLE;
          end
        end
        PH_SP_SDA:  phase_d = PH_SP_REL;
        PH_SP_REL:  if (!item_i.scl_stretched) phase_d = PH_SP_FREE;
        default:    phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    stage_d  = stage_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    bytes_d  = bytes_q;
    addr_d   = addr_q;
    reg_d    = reg_q;
    f_read_d = f_read_q;
    f_end_d  = f_end_q;
    f_ok_d   = f_ok_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    pop_o    = 1'b0;
    res_o    = '0;

    if (begin_i) begin
      if (phase_q == PH_IDLE && item_i.byte_count == '0) begin
        res_o.done_res = 1'b1;
      end else if (start_ok) begin
        addr_d   = item_i.device_address;
        reg_d    = item_i.register_command;
        bytes_d  = item_i.byte_count;
        stage_d  = STG_ADDR_W;
        shift_d  = {item_i.device_address, 1'b0};
        bit_d    = '0;
        f_read_d = (item_i.func == FUNC_READ);
        f_end_d  = (item_i.func == FUNC_READ) && item_i.end_with_stop;
        f_ok_d   = 1'b0;
      end
    end else if (tick_i) begin
      case (phase_q) inside
        PH_PRE_REL, PH_WB_REL, PH_WA_REL, PH_RS_REL, PH_RB_REL, PH_RK_REL,
        PH_SP_REL: begin
          scl_d = 1'b1;
        end
        PH_ST_SDA, PH_SP_SDA: begin
          sda_d = 1'b0;
        end
        PH_ST_SCL: begin
          scl_d = 1'b0;
          bit_d = '0;
        end
        PH_WB_SDA: begin
          sda_d   = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
        end
        PH_WB_LOW: begin
          scl_d = 1'b0;
          bit_d = bit_last ? '0 : bit_q + 3'd1;
        end
        PH_WA_SDA: begin
          sda_d = 1'b1;
        end
        PH_WA_LOW: begin
          scl_d = 1'b0;
          if (item_i.sda_sampled) begin
            f_ok_d = 1'b0;  // slave NAK
          end else begin
            case (stage_q)
              STG_ADDR_W: begin
                stage_d = STG_REG;
                shift_d = reg_q;
              end
              STG_REG: begin
                if (f_read_q) begin
                  stage_d = STG_ADDR_R;
                  shift_d = {addr_q, 1'b1};
                end else begin
                  stage_d = STG_DATA;
                end
              end
              STG_ADDR_R: begin
                shift_d = '0;
              end
              default: begin
                bytes_d = bytes_dec;
                if (bytes_dec_zero) f_ok_d = 1'b1;
              end
            endcase
          end
        end
        PH_LOAD: begin
          if (fifo_i.nonempty) begin
            shift_d = fifo_i.head_data;
            pop_o   = 1'b1;
            bit_d   = '0;
          end
        end
        PH_RB_LOW: begin
          shift_d = rd_shift;
          scl_d   = 1'b0;
          if (bit_last) begin
            bit_d          = '0;
            res_o.rx_byte  = rd_shift;
            res_o.rx_valid = 1'b1;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
        PH_RK_SDA: begin
          sda_d = (bytes_q <= 8'd1);  // NACK on the last byte
        end
        PH_RK_LOW: begin
          scl_d = 1'b0;
        end
        PH_RK_FREE: begin
          sda_d   = 1'b1;
          bytes_d = bytes_dec;
          if (!bytes_dec_zero) begin
            shift_d = '0;
          end else if (f_end_q) begin
            f_ok_d = 1'b1;
          end else begin
            res_o.done_res = 1'b1;
            res_o.success  = 1'b1;
          end
        end
        PH_SP_FREE: begin
          sda_d          = 1'b1;
          res_o.done_res = 1'b1;
          res_o.success  = f_ok_q;
        end
        default: begin
        end
      endcase
    end

    res_o.scl_drive   = scl_d;
    res_o.sda_drive   = sda_d;
    res_o.engine_busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      stage_q  <= STG_ADDR_W;
      bit_q    <= '0;
      shift_q  <= '0;
      bytes_q  <= '0;
      addr_q   <= '0;
      reg_q    <= '0;
      f_read_q <= 1'b0;
      f_end_q  <= 1'b0;
      f_ok_q   <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      stage_q  <= stage_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      bytes_q  <= bytes_d;
      addr_q   <= addr_d;
      reg_q    <= reg_d;
      f_read_q <= f_read_d;
      f_end_q  <= f_end_d;
      f_ok_q   <= f_ok_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
    end
  end

endmodule

### sv/i2c_master_register_burst_core.sv
// I2C master register burst core: top level with the result register.
// Depends on i2cmb_pkg, i2cmb_if, i2cmb_fifo and i2cmb_engine.
//
// Usage: every input beat on in_i carries one function code. A tick beat
// advances the bus sequence by at most one phase, begin-write and
// begin-read beats start a transfer when the engine is idle, and a push
// beat stores tx_byte in the transmit FIFO (TX_FIFO_DEPTH entries, pushes
// to a full FIFO are dropped). Every input beat yields exactly one result
// beat on out_o with the SCL/SDA drive levels after that beat, any
// completed read byte, the done/success flags and the busy flag.
// Latency: the result of a beat is valid in the cycle after it is taken.
// Throughput: one beat per cycle; the engine state and the result register
// both update in the accepting cycle, and the FIFO head is prefetched into
// a register so a data load never waits on the memory read port.
// Stall: in_i.ready is high while the result register is empty or being
// drained this cycle, so a stalled receiver holds the pending result and
// stops intake until it is taken.
// Reset: the engine goes idle with both lines released, the FIFO is empty
// and no result is pending. No clearing pass is needed.
module i2c_master_register_burst_core #(
  parameter int TX_FIFO_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cmb_in_if.sink     in_i,
  i2cmb_out_if.source  out_o
);
  import i2cmb_pkg::*;

  in_item_t   item;
  result_t    res;
  fifo_stat_t fifo_stat;
  logic       accept, tick, start, push, pop;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  assign item.func             = func_e'(in_i.func);
  assign item.device_address   = in_i.device_address;
  assign item.register_command = in_i.register_command;
  assign item.byte_count       = in_i.byte_count;
  assign item.tx_byte          = in_i.tx_byte;
  assign item.first_segment    = in_i.first_segment;
  assign item.end_with_stop    = in_i.end_with_stop;
  assign item.sda_sampled      = in_i.sda_sampled;
  assign item.scl_stretched    = in_i.scl_stretched;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign tick       = accept && (item.func == FUNC_TICK);
  assign start      = accept && (item.func == FUNC_WRITE || item.func == FUNC_READ);
  assign push       = accept && (item.func == FUNC_PUSH);

  i2cmb_fifo #(
    .TxFifoDepth (TX_FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (item.tx_byte),
    .pop_i       (pop),
    .stat_o      (fifo_stat)
  );

  i2cmb_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .begin_i (start),
    .item_i  (item),
    .fifo_i  (fifo_stat),
    .pop_o   (pop),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.scl_drive   = out_q.scl_drive;
  assign out_o.sda_drive   = out_q.sda_drive;
  assign out_o.rx_byte     = out_q.rx_byte;
  assign out_o.rx_valid    = out_q.rx_valid;
  assign out_o.done_res    = out_q.done_res;
  assign out_o.success     = out_q.success;
  assign out_o.engine_busy = out_q.engine_busy;

endmodule

### sv/i2cmb_checker.sv
// Port-level checks for the I2C master register burst core, with bind.
// Depends on i2c_master_register_burst_core and i2cmb_if.
module i2cmb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [13:0] out_word_i,
  input logic        rx_valid_i,
  input logic        done_i,
  input logic        success_i,
  input logic        busy_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("result payload changed while stalled");

  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready not tied to result drain");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (done_i || success_i) |-> done_i && !busy_i)
    else $error("success without done, or done while busy");

  a_rx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rx_valid_i |-> busy_i && !done_i)
    else $error("read byte reported outside a transfer");

endmodule

bind i2c_master_register_burst_core i2cmb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  ({out_o.scl_drive, out_o.sda_drive, out_o.rx_byte, out_o.rx_valid,
                 out_o.done_res, out_o.success, out_o.engine_busy}),
  .rx_valid_i  (out_o.rx_valid),
  .done_i      (out_o.done_res),
  .success_i   (out_o.success),
  .busy_i      (out_o.engine_busy)
);
